### hdl/okl_pkg.sv
package okl_pkg;

    localparam int KIND_W    = 3;
    localparam int KEY_W     = 64;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;

    // front queue depth
    localparam int QUEUE_DEPTH = 2;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POLL   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_INSERT,
        OP_POLL,
        OP_POP,
        OP_REMOVE,
        OP_SEARCH,
        OP_NOP
    } op_t;

    typedef enum logic {
        BK_CMP,
        BK_APPLY
    } back_state_t;

    typedef struct packed {
        op_t                    op;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]   payload;
    } cmd_t;

    // back unit -> cell row
    typedef struct packed {
        logic                    cmp_en;
        logic                    commit;
        op_t                     op;
        logic signed [KEY_W-1:0] key;
        logic [PAYLOAD_W-1:0]    payload;
    } cell_ctl_t;

    // cell row -> back unit
    typedef struct packed {
        logic                 any_gt;
        logic                 any_eq;
        logic [PAYLOAD_W-1:0] sel_data;
    } cell_stat_t;

    function automatic op_t decode_kind(input logic [KIND_W-1:0] kind);
        op_t op;
        unique case (kind)
            KIND_APPEND: op = OP_APPEND;
            KIND_INSERT: op = OP_INSERT;
            KIND_POLL:   op = OP_POLL;
            KIND_POP:    op = OP_POP;
            KIND_REMOVE: op = OP_REMOVE;
            KIND_SEARCH: op = OP_SEARCH;
            default:     op = OP_NOP;
        endcase
        return op;
    endfunction

endpackage

### hdl/okl_req_if.sv
interface okl_req_if import okl_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [KIND_W-1:0]       kind;
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;

    modport source (output valid, output kind, output key, output payload, input ready);
    modport sink   (input valid, input kind, input key, input payload, output ready);
endinterface

### hdl/okl_rsp_if.sv
interface okl_rsp_if import okl_pkg::*; #(
    parameter int CNT_W = 7
);
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] data_out;
    logic [CNT_W-1:0]     count;

    modport source (output valid, output status, output data_out, output count, input ready);
    modport sink   (input valid, input status, input data_out, input count, output ready);
endinterface

### hdl/okl_front.sv
module okl_front import okl_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    okl_req_if.sink    req,
    output cmd_t       cmd,
    output logic       cmd_valid,
    input  logic       cmd_ready
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QFW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           q_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QFW-1:0] fill_reg, fill_next;
    logic           push, pop;
    cmd_t           cmd_in;

    assign req.ready = (fill_reg != QFW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        cmd_in.op      = decode_kind(req.kind);
        cmd_in.key     = req.key;
        cmd_in.payload = req.payload;
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### hdl/okl_cells.sv
module okl_cells import okl_pkg::*; #(
    parameter int CAPACITY = 64,
    parameter int STORE_W  = 32,
    parameter int CNT_W    = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctl_t        ctl,
    input  logic [CNT_W-1:0] count,
    output cell_stat_t       stat
);

    localparam int LV = $clog2(CAPACITY);

    logic signed [KEY_W-1:0] key_reg  [CAPACITY];
    logic signed [KEY_W-1:0] key_next [CAPACITY];
    logic [STORE_W-1:0]      data_reg  [CAPACITY];
    logic [STORE_W-1:0]      data_next [CAPACITY];

    logic [CAPACITY-1:0] gt_now, eq_now, tail, last;
    logic [CAPACITY-1:0] gt_reg, eq_reg;
    logic [CAPACITY-1:0] gt_pf [LV+1];
    logic [CAPACITY-1:0] eq_pf [LV+1];
    logic [CAPACITY-1:0] pre_gt, pre_eq, incl_eq, first_gt, first_eq;
    logic [CAPACITY-1:0] new_at, shr, shl, sel;
    logic [STORE_W-1:0]  sel_acc;

    // log-depth prefix OR over the registered compare flags
    assign gt_pf[0] = gt_reg;
    assign eq_pf[0] = eq_reg;
    for (genvar l = 0; l < LV; l++)
    begin : g_pf
        assign gt_pf[l+1] = gt_pf[l] | (gt_pf[l] << (1 << l));
        assign eq_pf[l+1] = eq_pf[l] | (eq_pf[l] << (1 << l));
    end

    assign pre_gt   = gt_pf[LV] << 1;
    assign pre_eq   = eq_pf[LV] << 1;
    assign incl_eq  = eq_pf[LV];
    assign first_gt = gt_reg & ~pre_gt;
    assign first_eq = eq_reg & ~pre_eq;

    assign stat.any_gt   = gt_pf[LV][CAPACITY-1];
    assign stat.any_eq   = eq_pf[LV][CAPACITY-1];
    assign stat.sel_data = PAYLOAD_W'(sel_acc);

    always_comb
    begin
        new_at = '0;
        shr    = '0;
        shl    = '0;
        sel    = '0;
        unique case (ctl.op)
            OP_APPEND:
            begin
                new_at = tail;
            end
            OP_INSERT:
            begin
                new_at = stat.any_gt ? first_gt : tail;
                shr    = stat.any_gt ? pre_gt : '0;
            end
            OP_POLL:
            begin
                shl = '1;
                sel = CAPACITY'(1);
            end
            OP_POP:
            begin
                sel = last;
            end
            OP_REMOVE:
            begin
                shl = incl_eq;
                sel = first_eq;
            end
            OP_SEARCH:
            begin
                sel = first_eq;
            end
            default:
            begin
                sel = '0;
            end
        endcase
    end

    always_comb
    begin
        sel_acc = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel_acc = sel_acc | (data_reg[i] & {STORE_W{sel[i]}});
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        localparam int LEFT  = (g > 0) ? g - 1 : g;
        localparam int RIGHT = (g < CAPACITY - 1) ? g + 1 : g;

        logic occ;

        assign occ       = (CNT_W'(g) < count);
        assign gt_now[g] = occ && (key_reg[g] > ctl.key);
        assign eq_now[g] = occ && (key_reg[g] == ctl.key);
        assign tail[g]   = (CNT_W'(g) == count);
        assign last[g]   = (CNT_W'(g + 1) == count);

        always_comb
        begin
            key_next[g]  = key_reg[g];
            data_next[g] = data_reg[g];
            if (ctl.commit)
            begin
                if (new_at[g])
                begin
                    key_next[g]  = ctl.key;
                    data_next[g] = ctl.payload[STORE_W-1:0];
                end
                else if (shr[g])
                begin
                    key_next[g]  = key_reg[LEFT];
                    data_next[g] = data_reg[LEFT];
                end
                else if (shl[g])
                begin
                    key_next[g]  = key_reg[RIGHT];
                    data_next[g] = data_reg[RIGHT];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            key_reg[g]  <= key_next[g];
            data_reg[g] <= data_next[g];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gt_reg <= '0;
            eq_reg <= '0;
        end
        else if (ctl.cmp_en)
        begin
            gt_reg <= gt_now;
            eq_reg <= eq_now;
        end
    end

endmodule

### hdl/okl_back.sv
module okl_back import okl_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    okl_rsp_if.source                rsp
);

    localparam int STORE_W = (DATA_WIDTH < PAYLOAD_W) ? DATA_WIDTH : PAYLOAD_W;
    localparam int CNT_W   = $clog2(CAPACITY + 1);

    back_state_t          state_reg, state_next;
    cmd_t                 cmd_reg, cmd_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 res_valid_reg, res_valid_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [PAYLOAD_W-1:0] res_data_reg, res_data_next;
    logic [CNT_W-1:0]     res_count_reg;
    logic                 res_load, out_free;
    cell_ctl_t            ctl;
    cell_stat_t           stat;

    okl_cells #(
        .CAPACITY (CAPACITY),
        .STORE_W  (STORE_W),
        .CNT_W    (CNT_W)
    ) u_cells (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .count (count_reg),
        .stat  (stat)
    );

    assign out_free     = !res_valid_reg || rsp.ready;
    assign rsp.valid    = res_valid_reg;
    assign rsp.status   = res_status_reg;
    assign rsp.data_out = res_data_reg;
    assign rsp.count    = res_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        cmd_ready       = 1'b0;
        res_load        = 1'b0;
        res_status_next = ST_OK;
        res_data_next   = '0;
        ctl.cmp_en      = 1'b0;
        ctl.commit      = 1'b0;
        ctl.op          = cmd_reg.op;
        ctl.key         = cmd_reg.key;
        ctl.payload     = cmd_reg.payload;
        unique case (state_reg)
            BK_CMP:
            begin
                cmd_ready = 1'b1;
                ctl.key   = cmd.key;
                if (cmd_valid)
                begin
                    ctl.cmp_en = 1'b1;
                    cmd_next   = cmd;
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = BK_CMP;
                    case (cmd_reg.op) inside
                        OP_APPEND, OP_INSERT:
                        begin
                            if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                ctl.commit = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        OP_POLL, OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else
                            begin
                                ctl.commit    = 1'b1;
                                count_next    = count_reg - 1'b1;
                                res_data_next = stat.sel_data;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (!stat.any_eq)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else
                            begin
                                ctl.commit    = 1'b1;
                                count_next    = count_reg - 1'b1;
                                res_data_next = stat.sel_data;
                            end
                        end
                        OP_SEARCH:
                        begin
                            if (!stat.any_eq)
                            begin
                                res_status_next = ST_MISS;
                            end
                            else
                            begin
                                res_data_next = stat.sel_data;
                            end
                        end
                        default:
                        begin
                            res_status_next = ST_OK;
                        end
                    endcase
                end
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CMP;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        if (res_load)
        begin
            res_status_reg <= res_status_next;
            res_data_reg   <= res_data_next;
            res_count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_commit_in_apply: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.commit |-> (state_reg == BK_APPLY) && res_load)
        else $error("cell row changed outside the apply cycle");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !ctl.commit |=> $stable(count_reg))
        else $error("count moved without a committed operation");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_load && (res_status_next != ST_OK) |=> $stable(count_reg))
        else $error("refused or missed operation changed the store");

endmodule

### hdl/ordered_key_list_core.sv
// Ordered key list: holds up to CAPACITY entries (signed 64-bit key plus a data word kept in its
// low DATA_WIDTH bits, at most 32) and runs one operation per request item: append, ordered
// insert, poll head, pop tail, remove by key or search by key, each answered by exactly one
// response item carrying status, data and the entry count afterwards. A two-item front queue
// takes requests while the back unit works. The back unit handles each operation in a compare
// state, in which every cell of the cell row compares its key to the request key at once, and
// then an apply state, in which the row shifts and the response register loads; the cell row is
// busy for both, so the back unit takes no new request until the last one has been applied.
// A pending response that is not taken holds the back unit in its apply state. Count width on
// the response port is clog2(CAPACITY+1) bits.
module ordered_key_list_core import okl_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    okl_req_if.sink   req,
    okl_rsp_if.source rsp
);

    cmd_t cmd;
    logic cmd_valid;
    logic cmd_ready;

    okl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready)
    );

    okl_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );

endmodule
